// ===== rtl/core/sorted_key_table_top_assert.svh =====
// assertion macros used by the sequencer (sktab_ctrl)
`ifndef SORTED_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_KEY_TABLE_TOP_ASSERT_SVH

// same-cycle implication under synchronous reset
`define SKT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication under synchronous reset
`define SKT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/sktab_pkg.sv =====
package sktab_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 16;
  localparam int STATUS_W     = 3;
  localparam int OUT_IDX_W    = 5;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_FOUND     = 3'd0;
  localparam status_t ST_ABSENT    = 3'd1;
  localparam status_t ST_INSERTED  = 3'd2;
  localparam status_t ST_DUPLICATE = 3'd3;
  localparam status_t ST_FULL      = 3'd4;

  // function codes carried on the input side
  localparam logic FN_SEARCH = 1'b0;
  localparam logic FN_INSERT = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] id;
  } entry_t;

  // result of the shared compare unit
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

// ===== rtl/core/sktab_mem.sv =====
module sktab_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  sktab_pkg::entry_t wdata,
  input  logic [AW-1:0]     raddr,
  output sktab_pkg::entry_t rdata
);
  import sktab_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sktab_cmp.sv =====
module sktab_cmp (
  input  logic signed [sktab_pkg::DATA_W-1:0] a,
  input  logic signed [sktab_pkg::DATA_W-1:0] b,
  output sktab_pkg::cmp_res_t                 res
);
  import sktab_pkg::*;

  // signed two's complement compare of a stored key against the item key
  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
  end

endmodule

// ===== rtl/core/sktab_ctrl.sv =====
`include "sorted_key_table_top_assert.svh"

module sktab_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func_in,
  input  sktab_pkg::entry_t   item_in,
  output logic [AW-1:0]       raddr,
  input  sktab_pkg::entry_t   rdata,
  output logic                we,
  output logic [AW-1:0]       waddr,
  output sktab_pkg::entry_t   wdata,
  output logic signed [sktab_pkg::DATA_W-1:0] cmp_a,
  output logic signed [sktab_pkg::DATA_W-1:0] cmp_b,
  input  sktab_pkg::cmp_res_t cmp_res,
  output logic                res_valid,
  input  logic                res_ready,
  output sktab_pkg::status_t  res_status,
  output logic [CW-1:0]       res_pos,
  output logic [CW-1:0]       res_count
);
  import sktab_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN_RD  = 8'b0000_0010,
    S_SCAN_CMP = 8'b0000_0100,
    S_DECIDE   = 8'b0000_1000,
    S_SHIFT_RD = 8'b0001_0000,
    S_SHIFT_WR = 8'b0010_0000,
    S_PUT      = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] used, used_next;
  logic          func_r, func_r_next;
  entry_t        item_r, item_r_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos, pos_next;
  logic          hit, hit_next;
  status_t       status_r, status_r_next;

  always_comb begin
    state_next    = state;
    used_next     = used;
    func_r_next   = func_r;
    item_r_next   = item_r;
    idx_next      = idx;
    pos_next      = pos;
    hit_next      = hit;
    status_r_next = status_r;
    we            = 1'b0;
    waddr         = idx[AW-1:0];
    wdata         = rdata;
    raddr         = idx[AW-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          func_r_next = func_in;
          item_r_next = item_in;
          idx_next    = '0;
          pos_next    = '0;
          hit_next    = 1'b0;
          state_next  = (used == '0) ? S_DECIDE : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (cmp_res.eq) begin
          hit_next = 1'b1;
        end else if (cmp_res.lt) begin
          pos_next = pos + CW'(1);
        end
        idx_next   = idx + CW'(1);
        state_next = (idx + CW'(1) == used) ? S_DECIDE : S_SCAN_RD;
      end
      S_DECIDE: begin
        idx_next   = used;
        state_next = S_DONE;
        if (func_r == FN_SEARCH) begin
          status_r_next = hit ? ST_FOUND : ST_ABSENT;
        end else if (hit) begin
          status_r_next = ST_DUPLICATE;
        end else if (used == CW'(CAPACITY)) begin
          status_r_next = ST_FULL;
        end else begin
          status_r_next = ST_INSERTED;
          state_next    = (used == pos) ? S_PUT : S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        raddr      = AW'(idx - CW'(1));
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        we         = 1'b1;
        idx_next   = idx - CW'(1);
        state_next = (idx - CW'(1) == pos) ? S_PUT : S_SHIFT_RD;
      end
      S_PUT: begin
        we         = 1'b1;
        waddr      = pos[AW-1:0];
        wdata      = item_r;
        used_next  = used + CW'(1);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_r_next;
    item_r   <= item_r_next;
    idx      <= idx_next;
    pos      <= pos_next;
    hit      <= hit_next;
    status_r <= status_r_next;
  end

  assign in_ready   = (state == S_IDLE);
  assign cmp_a      = rdata.key;
  assign cmp_b      = item_r.key;
  assign res_valid  = (state == S_DONE);
  assign res_status = status_r;
  assign res_pos    = pos;
  assign res_count  = used;

  `SKT_ASSERT_IMP(a_used_bound, clk, rst, 1'b1, used <= CW'(CAPACITY))
  `SKT_ASSERT_IMP(a_scan_in_range, clk, rst, state == S_SCAN_CMP, idx < used)
  `SKT_ASSERT_IMP(a_shift_above_pos, clk, rst, state == S_SHIFT_WR, idx > pos)
  `SKT_ASSERT_NXT(a_put_grows, clk, rst, state == S_PUT, used == $past(used) + CW'(1))

endmodule

// ===== rtl/core/sorted_key_table_top.sv =====
// sorted key table: up to CAPACITY entries (signed key, id) kept in ascending key order
// input channel s_*: one transfer per item, tuser = func (search or insert),
//   tdata = key and entry_id; the item is answered by exactly one result
// output channel m_*: tdata = status, index, count of entries after the item
// each item is handled by a sequencer that walks the table memory through one
//   shared compare unit, one read port and one write port
// per item, a search or a rejected insert reads and compares every entry in turn, then decides;
//   a successful insert then shifts each entry at or above index up one slot and writes the item
// throughput: one item at a time; s_tready is high only while the sequencer idles
// results land in an output register, so the next item is taken while a result
//   still waits on m_tready; a stalled receiver holds m_tdata steady and
//   halts the sequencer only when it has a further result to hand over
// reset (rst, synchronous, active high) empties the table and drops any
//   pending result; table contents need no clearing
module sorted_key_table_top #(
  parameter int CAPACITY = sktab_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // key [31:0], entry_id [63:32]
  input  logic [0:0]  s_tuser,   // func [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status [2:0], index [7:3], count [12:8], zero [15:13]
);
  import sktab_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // table memory port
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;
  entry_t        rdata;
  entry_t        wdata;

  // shared compare unit
  logic signed [DATA_W-1:0] cmp_a;
  logic signed [DATA_W-1:0] cmp_b;
  cmp_res_t                 cmp_res;

  // result handoff from the sequencer
  logic          res_valid;
  logic          res_ready;
  status_t       res_status;
  logic [CW-1:0] res_pos;
  logic [CW-1:0] res_count;

  entry_t item_in;

  assign item_in.key = s_tdata[31:0];
  assign item_in.id  = s_tdata[63:32];

  sktab_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  sktab_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  sktab_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .func_in    (s_tuser[0]),
    .item_in    (item_in),
    .raddr      (raddr),
    .rdata      (rdata),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .cmp_a      (cmp_a),
    .cmp_b      (cmp_b),
    .cmp_res    (cmp_res),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status),
    .res_pos    (res_pos),
    .res_count  (res_count)
  );

  // output register is free when empty or emptied in this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // index and count are reported modulo 32
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {3'b000, OUT_IDX_W'(res_count), OUT_IDX_W'(res_pos), res_status};
    end
  end

endmodule

// ===== tb/sorted_key_table_top_tb.sv =====
module sorted_key_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sktab_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  // one result as the table reports it
  typedef struct packed {
    status_t    status;
    logic [4:0] index;
    logic [4:0] count;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // key [31:0], entry_id [63:32]
  logic [0:0]  s_tuser = '0;   // func [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // status [2:0], index [7:3], count [12:8]

  // shadow copy of the sorted table, updated when an accepted insert succeeds
  logic signed [31:0] shadow_keys [CAP];
  int                 shadow_used = 0;

  table_reply_t reply_q [$];   // replies still owed by the block, oldest first
  table_reply_t want;
  int           mismatches = 0;
  bit           calm = 1'b0;   // set: neither side idles

  sorted_key_table_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #1_500_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit key_present(input logic signed [31:0] key);
    for (int i = 0; i < shadow_used; i++) begin
      if (shadow_keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // reply for one item; a successful insert also updates the shadow table
  function automatic table_reply_t apply_item(input logic fn, input logic signed [31:0] key);
    int           below;
    bit           hit;
    table_reply_t r;
    below = 0;
    hit   = key_present(key);
    for (int i = 0; i < shadow_used; i++) begin
      if (shadow_keys[i] < key) below++;
    end
    if (fn == FN_SEARCH) begin
      r.status = hit ? ST_FOUND : ST_ABSENT;
    end else if (hit) begin
      // duplicate wins over full
      r.status = ST_DUPLICATE;
    end else if (shadow_used >= CAP) begin
      r.status = ST_FULL;
    end else begin
      for (int i = shadow_used; i > below; i--) shadow_keys[i] = shadow_keys[i-1];
      shadow_keys[below] = key;
      shadow_used++;
      r.status = ST_INSERTED;
    end
    r.index = below[4:0];
    r.count = shadow_used[4:0];
    return r;
  endfunction

  // keys biased toward entries already held and their neighbors
  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    int          sel;
    sel = $urandom_range(99);
    if (shadow_used == 0 || sel < 25) begin
      k = $urandom();
    end else if (sel < 60) begin
      k = shadow_keys[$urandom_range(shadow_used - 1)];
    end else if (sel < 75) begin
      k = shadow_keys[$urandom_range(shadow_used - 1)] + 32'sd1;
    end else if (sel < 90) begin
      k = shadow_keys[$urandom_range(shadow_used - 1)] - 32'sd1;
    end else begin
      case ($urandom_range(3))
        0: k = 32'h8000_0000;
        1: k = 32'h7fff_ffff;
        2: k = 32'h0000_0000;
        default: k = 32'hffff_ffff;
      endcase
    end
    return k;
  endfunction

  // one input transfer; the prediction is taken at the accepting edge
  task automatic send_item(input logic fn, input logic [31:0] key, input logic [31:0] eid);
    if (!calm && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {eid, key};
    s_tuser  <= fn;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    reply_q.push_back(apply_item(fn, key));
  endtask

  // sender holds off until every owed reply has come back
  task automatic wait_replies();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  // searches on the empty table: absent at position zero
  task automatic test_empty_table();
    send_item(FN_SEARCH, 32'h0000_0000, 32'h0000_0000);
    send_item(FN_SEARCH, 32'h8000_0000, 32'hffff_ffff);
    send_item(FN_SEARCH, 32'h7fff_ffff, 32'h8000_0000);
    wait_replies();
  endtask

  // extreme keys and ids, hits, misses and a duplicate
  task automatic test_extreme_keys();
    send_item(FN_INSERT, 32'h0000_0000, 32'h7fff_ffff);   // into empty table
    send_item(FN_INSERT, 32'hffff_ffff, 32'h8000_0000);   // in front of zero
    send_item(FN_INSERT, 32'h8000_0000, 32'hffff_ffff);   // most negative, at the front
    send_item(FN_INSERT, 32'h0000_0005, 32'h0000_0000);   // append at the end
    send_item(FN_INSERT, 32'h0000_0002, 32'h5a5a_a5a5);   // between two entries
    send_item(FN_SEARCH, 32'h8000_0000, 32'h1234_5678);
    send_item(FN_SEARCH, 32'h0000_0005, 32'h0000_0000);
    send_item(FN_SEARCH, 32'hffff_ffff, 32'hffff_ffff);
    send_item(FN_SEARCH, 32'h0000_0001, 32'h0000_0000);   // absent, mid position
    send_item(FN_SEARCH, 32'h7fff_ffff, 32'h0000_0000);   // absent, past the end
    send_item(FN_SEARCH, 32'h8000_0001, 32'h0000_0000);   // absent, just above the front
    send_item(FN_INSERT, 32'h8000_0000, 32'h0000_0001);   // duplicate is rejected
    wait_replies();
  endtask

  // random mix of searches and inserts; new_pct steers how often an insert
  // tries a fresh key rather than an existing one
  task automatic test_random_mix(input int n_items, input int new_pct,
                                 input int calm_lo, input int calm_hi);
    logic        fn;
    logic [31:0] k;
    for (int n = 0; n < n_items; n++) begin
      calm = (n >= calm_lo) && (n < calm_hi);
      fn   = ($urandom_range(99) < 35) ? FN_INSERT : FN_SEARCH;
      if (fn == FN_INSERT && shadow_used != 0 && $urandom_range(99) >= new_pct) begin
        k = shadow_keys[$urandom_range(shadow_used - 1)];
      end else begin
        k = pick_key();
      end
      send_item(fn, k, $urandom());
      if (!calm && $urandom_range(99) == 0) wait_replies();
    end
    calm = 1'b0;
    wait_replies();
  endtask

  // fill up, then full and duplicate rejects on the full table
  task automatic test_full_table();
    logic [31:0] k;
    while (shadow_used < CAP) begin
      k = $urandom();
      if (!key_present(k)) send_item(FN_INSERT, k, $urandom());
    end
    k = $urandom();
    while (key_present(k)) k = $urandom();
    send_item(FN_INSERT, k, $urandom());                                // full, at a random position
    send_item(FN_INSERT, 32'h7fff_ffff, $urandom());                    // full at the end, or dup
    send_item(FN_INSERT, shadow_keys[$urandom_range(CAP - 1)], 32'h0);  // dup beats full
    send_item(FN_SEARCH, shadow_keys[CAP - 1], $urandom());
    send_item(FN_SEARCH, k, $urandom());
    wait_replies();
  endtask

  // receiver stalls at random unless calm
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 13);
  end

  // every output transfer is checked against the oldest owed reply
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (reply_q.size() == 0) begin
        $error("result with none owed: m_tdata %h", m_tdata);
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        if (m_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
          mismatches++;
        end
        if (m_tdata[7:3] !== want.index) begin
          $error("index: expected %0d, actual %0d", want.index, m_tdata[7:3]);
          mismatches++;
        end
        if (m_tdata[12:8] !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, m_tdata[12:8]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_extreme_keys();
    // table fills slowly here, with a stretch of no idling in the middle
    test_random_mix(1000, 8, 400, 600);
    test_full_table();
    // the table stays full from here on
    test_random_mix(650, 100, 0, 0);
    // let any stray late result show up
    repeat (80) @(posedge clk);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sktab_pkg.sv
rtl/core/sktab_mem.sv
rtl/core/sktab_cmp.sv
rtl/core/sktab_ctrl.sv
rtl/core/sorted_key_table_top.sv
tb/sorted_key_table_top_tb.sv
